>>> design/sorted_event_time_table_unit_defines.svh
// Assertion macros shared by the event time table RTL.
`ifndef SORTED_EVENT_TIME_TABLE_UNIT_DEFINES_SVH
`define SORTED_EVENT_TIME_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SETT_ASSERT_IMPL(name, clock, rstn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SETT_ASSERT_NEXT(name, clock, rstn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sett_pkg.sv
// Shared types and constants of the sorted event time table.
package sett_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_TIME_WIDTH  = 32;

    localparam int MODE_W   = 3;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 11;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_REM_TIME  = 3'd1,
        OP_REM_TAG   = 3'd2,
        OP_FIND_TIME = 3'd3,
        OP_FIND_TAG  = 3'd4,
        OP_RANGE     = 3'd5,
        OP_CLEAR     = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_KEEP = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_APPLY  = 2'd2
    } state_t;

    // Per-cell search flags fed to the reduction trees.
    typedef struct packed {
        logic lb_hit;   // valid and (time >= key, or tag == key in tag mode)
        logic eq;       // time == key
        logic ub_hit;   // valid and time > end
    } cell_flags_t;

endpackage

>>> design/sett_in_if.sv
// Request channel interface of the sorted event time table.
interface sett_in_if;
    logic                          valid;
    logic                          ready;
    logic [sett_pkg::MODE_W-1:0]   mode;
    logic [sett_pkg::KEY_W-1:0]    time_key;
    logic [sett_pkg::KEY_W-1:0]    time_end;
    logic [sett_pkg::TAG_W-1:0]    entity_key;

    modport source (output valid, mode, time_key, time_end, entity_key, input ready);
    modport sink   (input valid, mode, time_key, time_end, entity_key, output ready);
endinterface

>>> design/sett_out_if.sv
// Response channel interface of the sorted event time table.
interface sett_out_if;
    logic                            valid;
    logic                            ready;
    logic [sett_pkg::STATUS_W-1:0]   status;
    logic [sett_pkg::POS_W-1:0]      position;
    logic [sett_pkg::POS_W-1:0]      position_end;
    logic [sett_pkg::POS_W-1:0]      occupancy;

    modport source (output valid, status, position, position_end, occupancy, input ready);
    modport sink   (input valid, status, position, position_end, occupancy, output ready);
endinterface

>>> design/sorted_event_time_table_unit.sv
// Sorted event time table top level: row of cells, two first-hit trees, control FSM.
// Sequence: accept, search while the registered trees settle, then apply once the output
//   stage is free. A new request is taken only in idle, after the last one is applied.
// Reset (rst_n low, async) empties the table and the output stage; cell contents keep
//   whatever they hold and need no clearing pass.
`include "sorted_event_time_table_unit_defines.svh"

module sorted_event_time_table_unit #(
    parameter int TABLE_DEPTH = sett_pkg::DEF_TABLE_DEPTH,
    parameter int TIME_WIDTH  = sett_pkg::DEF_TIME_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sett_in_if.sink    req,
    sett_out_if.source rsp
);

    localparam int CNTW   = $clog2(TABLE_DEPTH + 1);
    localparam int LEVELS = $clog2(TABLE_DEPTH);
    localparam int LVLW   = $clog2(LEVELS + 1);

    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(TABLE_DEPTH);

    // Control and request registers
    sett_pkg::state_t            state_reg, state_next;
    logic [LVLW-1:0]             wait_reg, wait_next;
    logic [sett_pkg::MODE_W-1:0] mode_reg;
    logic [TIME_WIDTH-1:0]       key_reg;
    logic [TIME_WIDTH-1:0]       end_reg;
    logic [sett_pkg::TAG_W-1:0]  tag_reg;
    logic [CNTW-1:0]             count_reg, count_next;

    // Output stage
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [sett_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [sett_pkg::POS_W-1:0]    rsp_pos_reg;
    logic [sett_pkg::POS_W-1:0]    rsp_end_reg;
    logic [sett_pkg::POS_W-1:0]    rsp_occ_reg;

    logic accept;
    logic apply_fire;
    logic tag_search;

    // Broadcast command to the cell row
    sett_pkg::cell_op_t cell_op;
    logic [CNTW-1:0]    cell_pos;

    // Cell row
    logic [TIME_WIDTH-1:0]      cell_time [TABLE_DEPTH];
    logic [sett_pkg::TAG_W-1:0] cell_tag  [TABLE_DEPTH];
    sett_pkg::cell_flags_t      cell_flags [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     lb_vec, eq_vec, ub_vec;

    // Tree roots
    logic              a_found, a_eq;
    logic [LEVELS-1:0] a_idx;
    logic              b_found;
    logic [LEVELS-1:0] b_idx;

    logic [CNTW-1:0]         lb_pos, ub_pos;
    logic                    time_hit;
    sett_pkg::status_t       res_status;
    logic [CNTW-1:0]         res_pos, res_end;

    assign accept     = req.valid && req.ready;
    assign tag_search = (mode_reg == sett_pkg::OP_REM_TAG) || (mode_reg == sett_pkg::OP_FIND_TAG);

    // Request capture; time fields are cut or zero-extended to the stored width.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            key_reg  <= TIME_WIDTH'(req.time_key);
            end_reg  <= TIME_WIDTH'(req.time_end);
            tag_reg  <= req.entity_key;
        end
    end

    // Cell row: each cell shifts from its left neighbor on insert, from its right on delete.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [TIME_WIDTH-1:0]      lt, rt;
        logic [sett_pkg::TAG_W-1:0] lg, rg;

        if (i == 0)
        begin : g_first
            assign lt = key_reg;
            assign lg = tag_reg;
        end
        else
        begin : g_left
            assign lt = cell_time[i-1];
            assign lg = cell_tag[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign rt = cell_time[i];
            assign rg = cell_tag[i];
        end
        else
        begin : g_right
            assign rt = cell_time[i+1];
            assign rg = cell_tag[i+1];
        end

        sett_cell #(
            .TIME_WIDTH (TIME_WIDTH),
            .CNTW       (CNTW),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .pos        (cell_pos),
            .new_time   (key_reg),
            .new_tag    (tag_reg),
            .left_time  (lt),
            .left_tag   (lg),
            .right_time (rt),
            .right_tag  (rg),
            .key_time   (key_reg),
            .end_time   (end_reg),
            .key_tag    (tag_reg),
            .tag_search (tag_search),
            .count      (count_reg),
            .time_q     (cell_time[i]),
            .tag_q      (cell_tag[i]),
            .flags      (cell_flags[i])
        );

        assign lb_vec[i] = cell_flags[i].lb_hit;
        assign eq_vec[i] = cell_flags[i].eq;
        assign ub_vec[i] = cell_flags[i].ub_hit;
    end

    // Tree A: lower bound of the key (or first tag match), with equality of the hit.
    sett_first_tree #(
        .DEPTH  (TABLE_DEPTH),
        .LEVELS (LEVELS)
    ) u_tree_lb (
        .clk       (clk),
        .leaf_flag (lb_vec),
        .leaf_eq   (eq_vec),
        .found     (a_found),
        .eq        (a_eq),
        .idx       (a_idx)
    );

    // Tree B: upper bound of the range end.
    sett_first_tree #(
        .DEPTH  (TABLE_DEPTH),
        .LEVELS (LEVELS)
    ) u_tree_ub (
        .clk       (clk),
        .leaf_flag (ub_vec),
        .leaf_eq   ('0),
        .found     (b_found),
        .eq        (),
        .idx       (b_idx)
    );

    // No hit means the bound sits at the end of the stored entries.
    assign lb_pos   = a_found ? CNTW'(a_idx) : count_reg;
    assign ub_pos   = b_found ? CNTW'(b_idx) : count_reg;
    assign time_hit = a_found && a_eq;

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            sett_pkg::S_IDLE:
            begin
                wait_next = '0;
                if (accept)
                begin
                    state_next = sett_pkg::S_SEARCH;
                end
            end
            sett_pkg::S_SEARCH:
            begin
                // Stay in search until the tree roots have settled after the request registers load.
                wait_next = wait_reg + LVLW'(1);
                if (wait_reg == LVLW'(LEVELS - 1))
                begin
                    state_next = sett_pkg::S_APPLY;
                end
            end
            sett_pkg::S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = sett_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sett_pkg::S_IDLE;
            end
        endcase
    end

    // FSM outputs: take a request only when idle; apply once the output stage is free.
    always_comb
    begin
        req.ready  = 1'b0;
        apply_fire = 1'b0;
        case (state_reg)
            sett_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            sett_pkg::S_APPLY:
            begin
                apply_fire = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready  = 1'b0;
                apply_fire = 1'b0;
            end
        endcase
    end

    // Operation result and table edit
    always_comb
    begin
        res_status = sett_pkg::ST_DONE;
        res_pos    = '0;
        res_end    = '0;
        count_next = count_reg;
        cell_op    = sett_pkg::CELL_KEEP;
        cell_pos   = lb_pos;
        case (sett_pkg::mode_t'(mode_reg))
            sett_pkg::OP_INSERT:
            begin
                if (time_hit)
                begin
                    // duplicate time is checked before fullness
                    res_status = sett_pkg::ST_MISS;
                    res_pos    = lb_pos;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    res_status = sett_pkg::ST_FULL;
                end
                else
                begin
                    res_pos    = lb_pos;
                    count_next = count_reg + CNTW'(1);
                    cell_op    = sett_pkg::CELL_INS;
                end
            end
            sett_pkg::OP_REM_TIME,
            sett_pkg::OP_FIND_TIME:
            begin
                if (time_hit)
                begin
                    res_pos = lb_pos;
                    if (mode_reg == sett_pkg::OP_REM_TIME)
                    begin
                        count_next = count_reg - CNTW'(1);
                        cell_op    = sett_pkg::CELL_DEL;
                    end
                end
                else
                begin
                    res_status = sett_pkg::ST_MISS;
                end
            end
            sett_pkg::OP_REM_TAG,
            sett_pkg::OP_FIND_TAG:
            begin
                cell_pos = CNTW'(a_idx);
                if (a_found)
                begin
                    res_pos = CNTW'(a_idx);
                    if (mode_reg == sett_pkg::OP_REM_TAG)
                    begin
                        count_next = count_reg - CNTW'(1);
                        cell_op    = sett_pkg::CELL_DEL;
                    end
                end
                else
                begin
                    res_status = sett_pkg::ST_MISS;
                end
            end
            sett_pkg::OP_RANGE:
            begin
                res_pos = lb_pos;
                res_end = ub_pos;
            end
            sett_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // unused mode: no change, report current occupancy
                count_next = count_reg;
            end
        endcase
        if (!apply_fire)
        begin
            cell_op    = sett_pkg::CELL_KEEP;
            count_next = count_reg;
        end
    end

    assign rsp_valid_next = apply_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sett_pkg::S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Output payload; fields are 11 bits wide whatever the table depth.
    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            rsp_status_reg <= res_status;
            rsp_pos_reg    <= sett_pkg::POS_W'(res_pos);
            rsp_end_reg    <= sett_pkg::POS_W'(res_end);
            rsp_occ_reg    <= sett_pkg::POS_W'(count_next);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.position     = rsp_pos_reg;
    assign rsp.position_end = rsp_end_reg;
    assign rsp.occupancy    = rsp_occ_reg;

    // Assertions
    `SETT_ASSERT_IMPL(a_count_bounded, clk, rst_n, 1'b1, count_reg <= FULL_COUNT, "entry count above table depth")
    `SETT_ASSERT_NEXT(a_apply_delivers, clk, rst_n, apply_fire, rsp.valid && state_reg == sett_pkg::S_IDLE, "applied operation did not produce a result")
    `SETT_ASSERT_NEXT(a_insert_grows, clk, rst_n, apply_fire && cell_op == sett_pkg::CELL_INS, count_reg == $past(count_reg) + CNTW'(1), "insert did not grow the table by one")
    `SETT_ASSERT_IMPL(a_full_occupancy, clk, rst_n, rsp.valid && rsp.status == sett_pkg::ST_FULL, rsp.occupancy == sett_pkg::POS_W'(TABLE_DEPTH), "full status with table not full")

endmodule

>>> design/sett_cell.sv
// One table cell: holds one time/tag pair, shifts with its neighbors, flags search hits.
module sett_cell #(
    parameter int TIME_WIDTH = sett_pkg::DEF_TIME_WIDTH,
    parameter int CNTW       = 11,
    parameter int INDEX      = 0
) (
    input  logic                          clk,
    input  sett_pkg::cell_op_t            op,
    input  logic [CNTW-1:0]               pos,
    input  logic [TIME_WIDTH-1:0]         new_time,
    input  logic [sett_pkg::TAG_W-1:0]    new_tag,
    input  logic [TIME_WIDTH-1:0]         left_time,
    input  logic [sett_pkg::TAG_W-1:0]    left_tag,
    input  logic [TIME_WIDTH-1:0]         right_time,
    input  logic [sett_pkg::TAG_W-1:0]    right_tag,
    input  logic [TIME_WIDTH-1:0]         key_time,
    input  logic [TIME_WIDTH-1:0]         end_time,
    input  logic [sett_pkg::TAG_W-1:0]    key_tag,
    input  logic                          tag_search,
    input  logic [CNTW-1:0]               count,
    output logic [TIME_WIDTH-1:0]         time_q,
    output logic [sett_pkg::TAG_W-1:0]    tag_q,
    output sett_pkg::cell_flags_t         flags
);

    localparam logic [CNTW-1:0] MY_IDX = CNTW'(INDEX);

    logic [TIME_WIDTH-1:0]      time_reg, time_next;
    logic [sett_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic                       occupied;

    always_comb
    begin
        time_next = time_reg;
        tag_next  = tag_reg;
        case (op)
            sett_pkg::CELL_INS:
            begin
                if (MY_IDX > pos)
                begin
                    time_next = left_time;
                    tag_next  = left_tag;
                end
                else if (MY_IDX == pos)
                begin
                    time_next = new_time;
                    tag_next  = new_tag;
                end
            end
            sett_pkg::CELL_DEL:
            begin
                if (MY_IDX >= pos)
                begin
                    time_next = right_time;
                    tag_next  = right_tag;
                end
            end
            default:
            begin
                time_next = time_reg;
                tag_next  = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
    end

    assign occupied     = MY_IDX < count;
    assign flags.lb_hit = occupied && (tag_search ? (tag_reg == key_tag) : (time_reg >= key_time));
    assign flags.eq     = time_reg == key_time;
    assign flags.ub_hit = occupied && (time_reg > end_time);

    assign time_q = time_reg;
    assign tag_q  = tag_reg;

endmodule

>>> design/sett_first_tree.sv
// Registered binary tree that finds the lowest-indexed set flag, one level per cycle.
module sett_first_tree #(
    parameter int DEPTH  = sett_pkg::DEF_TABLE_DEPTH,
    parameter int LEVELS = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic [DEPTH-1:0]  leaf_flag,
    input  logic [DEPTH-1:0]  leaf_eq,
    output logic              found,
    output logic              eq,
    output logic [LEVELS-1:0] idx
);

    localparam int N = 1 << LEVELS;

    typedef struct packed {
        logic              found;
        logic              eq;
        logic [LEVELS-1:0] idx;
    } node_t;

    node_t leaf_w   [N];
    node_t node_reg [N-1];

    for (genvar j = 0; j < N; j++)
    begin : g_leaf
        if (j < DEPTH)
        begin : g_real
            assign leaf_w[j] = '{found: leaf_flag[j], eq: leaf_eq[j], idx: LEVELS'(j)};
        end
        else
        begin : g_pad
            assign leaf_w[j] = '0;
        end
    end

    // Heap order: node k has children 2k+1 and 2k+2; the left one wins when it hits.
    for (genvar k = 0; k < N - 1; k++)
    begin : g_node
        node_t lft, rgt;
        if (2 * k + 1 >= N - 1)
        begin : g_from_leaf
            assign lft = leaf_w[2 * k + 1 - (N - 1)];
            assign rgt = leaf_w[2 * k + 2 - (N - 1)];
        end
        else
        begin : g_from_node
            assign lft = node_reg[2 * k + 1];
            assign rgt = node_reg[2 * k + 2];
        end

        always_ff @(posedge clk)
        begin
            node_reg[k] <= lft.found ? lft : rgt;
        end
    end

    assign found = node_reg[0].found;
    assign eq    = node_reg[0].eq;
    assign idx   = node_reg[0].idx;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench of the sorted event time table unit.
`timescale 1ns / 100ps

module tb_top;
    import sett_pkg::*;

    localparam int          TABLE_DEPTH   = DEF_TABLE_DEPTH;
    localparam int          IDLE_MAX      = 17;     // longest gap or stall per transaction
    localparam int          ITEMS_TARGET  = 1850;   // stop point of the random part
    localparam int          SETTLE_CYCLES = 16;     // extra wait after the response queue drains
    localparam int          MAX_REPORTS   = 10;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;   // no-op encoding
    localparam logic [KEY_W-1:0]  ALL_ONES    = 32'hFFFF_FFFF;

    // One response as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    position_end;
        logic [POS_W-1:0]    occupancy;
    } txn_result_t;

    // Directed row: request fields, plus a typed-in result when `fixed` is set.
    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  tk;
        logic [KEY_W-1:0]  te;
        logic [TAG_W-1:0]  tag;
        logic              fixed;
        txn_result_t       res;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    logic clk;
    logic rst_n;

    sett_in_if  req_ch ();
    sett_out_if rsp_ch ();

    sorted_event_time_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table: times ascending, tags alongside.
    logic [KEY_W-1:0] shadow_times [TABLE_DEPTH];
    logic [TAG_W-1:0] shadow_tags  [TABLE_DEPTH];
    int unsigned      shadow_count;

    txn_result_t table_results_q [$];   // responses still owed by the block, oldest first

    int unsigned cycle_count;
    int unsigned issued_count;
    int unsigned fault_count;
    int unsigned checked_count;
    int unsigned insert_count;
    int unsigned full_count;
    int unsigned miss_count;
    int unsigned peak_occupancy;
    bit          sender_calm;   // stretch with back-to-back requests
    bit          sink_calm;     // stretch with ready held high

    // Directed part. Empty-table results, extremes and miss codes are typed in;
    // rows that depend on tag order or shifts go through the shadow table.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty table right after reset
        '{OP_FIND_TIME, 32'h0,      32'h0,    32'h0,    1'b1, '{ST_MISS, 11'd0, 11'd0, 11'd0}},
        '{OP_FIND_TAG,  32'h0,      32'h0,    32'h0,    1'b1, '{ST_MISS, 11'd0, 11'd0, 11'd0}},
        '{OP_REM_TIME,  32'h0,      32'h0,    32'h0,    1'b1, '{ST_MISS, 11'd0, 11'd0, 11'd0}},
        '{OP_REM_TAG,   32'h0,      32'h0,    ALL_ONES, 1'b1, '{ST_MISS, 11'd0, 11'd0, 11'd0}},
        '{OP_RANGE,     32'h0,      ALL_ONES, 32'h0,    1'b1, '{ST_DONE, 11'd0, 11'd0, 11'd0}},
        // extreme times, then duplicates of each
        '{OP_INSERT,    ALL_ONES,   32'h0,    ALL_ONES, 1'b1, '{ST_DONE, 11'd0, 11'd0, 11'd1}},
        '{OP_INSERT,    32'h0,      32'h0,    32'h0,    1'b1, '{ST_DONE, 11'd0, 11'd0, 11'd2}},
        '{OP_INSERT,    32'h0,      32'h0,    32'h5,    1'b1, '{ST_MISS, 11'd0, 11'd0, 11'd2}},
        '{OP_INSERT,    ALL_ONES,   32'h0,    32'h7,    1'b1, '{ST_MISS, 11'd1, 11'd0, 11'd2}},
        '{OP_RANGE,     32'h0,      ALL_ONES, 32'h0,    1'b1, '{ST_DONE, 11'd0, 11'd2, 11'd2}},
        // start above end: bounds come back crossed or equal
        '{OP_RANGE,     ALL_ONES,   32'h0,    32'h0,    1'b1, '{ST_DONE, 11'd1, 11'd1, 11'd2}},
        '{MODE_UNUSED,  32'h0,      32'h0,    32'h0,    1'b1, '{ST_DONE, 11'd0, 11'd0, 11'd2}},
        // two entries sharing one tag: lowest index wins
        '{OP_INSERT,    32'h5555_5555, 32'h0, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_INSERT,    32'hAAAA_AAAA, 32'h0, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_FIND_TAG,  32'h0,      32'h0,    32'hAAAA_AAAA, 1'b0, '0},
        '{OP_FIND_TIME, 32'hAAAA_AAAA, 32'h0, 32'h0,    1'b0, '0},
        '{OP_RANGE,     32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b0, '0},
        '{OP_RANGE,     32'h6000_0000, 32'h5000_0000, 32'h0, 1'b0, '0},
        '{OP_REM_TAG,   32'h0,      32'h0,    32'hAAAA_AAAA, 1'b0, '0},
        '{OP_REM_TIME,  ALL_ONES,   32'h0,    32'h0,    1'b0, '0},
        '{OP_FIND_TAG,  32'h0,      32'h0,    32'hAAAA_AAAA, 1'b0, '0},
        '{MODE_UNUSED,  ALL_ONES,   ALL_ONES, ALL_ONES, 1'b0, '0},
        '{OP_CLEAR,     ALL_ONES,   ALL_ONES, ALL_ONES, 1'b1, '{ST_DONE, 11'd0, 11'd0, 11'd0}},
        '{OP_FIND_TIME, 32'h0,      32'h0,    32'h0,    1'b1, '{ST_MISS, 11'd0, 11'd0, 11'd0}}
    };

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, table_results_q.size());
        $display("FAIL sorted_event_time_table_unit");
        $finish;
    end

    // ---------------------------------------------------------------
    // Shadow table helpers
    // ---------------------------------------------------------------

    // First index whose time is >= t (upper clear) or > t (upper set).
    function automatic int unsigned time_bound(logic [KEY_W-1:0] t, bit upper);
        int unsigned i;
        for (i = 0; i < shadow_count; i++)
            if (upper ? (shadow_times[i] > t) : (shadow_times[i] >= t))
                return i;
        return shadow_count;
    endfunction

    // Lowest index holding the tag, -1 if absent.
    function automatic int tag_index(logic [TAG_W-1:0] tag);
        int unsigned i;
        for (i = 0; i < shadow_count; i++)
            if (shadow_tags[i] == tag)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(int unsigned idx);
        int unsigned i;
        for (i = idx; i + 1 < shadow_count; i++)
        begin
            shadow_times[i] = shadow_times[i + 1];
            shadow_tags[i]  = shadow_tags[i + 1];
        end
        shadow_count--;
    endfunction

    // Applies one operation to the shadow table and returns the response it owes.
    function automatic txn_result_t table_op(logic [MODE_W-1:0] op, logic [KEY_W-1:0] tk,
                                             logic [KEY_W-1:0] te, logic [TAG_W-1:0] tag);
        txn_result_t r;
        int unsigned idx;
        int unsigned i;
        int          hit;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                idx = time_bound(tk, 1'b0);
                if (idx < shadow_count && shadow_times[idx] == tk)
                begin
                    // duplicate wins over full
                    r.status   = ST_MISS;
                    r.position = POS_W'(idx);
                end
                else if (shadow_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_count; i > idx; i--)
                    begin
                        shadow_times[i] = shadow_times[i - 1];
                        shadow_tags[i]  = shadow_tags[i - 1];
                    end
                    shadow_times[idx] = tk;
                    shadow_tags[idx]  = tag;
                    shadow_count++;
                    r.position = POS_W'(idx);
                end
            end
            OP_REM_TIME, OP_FIND_TIME:
            begin
                idx = time_bound(tk, 1'b0);
                if (idx < shadow_count && shadow_times[idx] == tk)
                begin
                    r.position = POS_W'(idx);
                    if (op == OP_REM_TIME)
                        drop_entry(idx);
                end
                else
                    r.status = ST_MISS;
            end
            OP_REM_TAG, OP_FIND_TAG:
            begin
                hit = tag_index(tag);
                if (hit >= 0)
                begin
                    r.position = POS_W'(hit);
                    if (op == OP_REM_TAG)
                        drop_entry(hit);
                end
                else
                    r.status = ST_MISS;
            end
            OP_RANGE:
            begin
                r.position     = POS_W'(time_bound(tk, 1'b0));
                r.position_end = POS_W'(time_bound(te, 1'b1));
            end
            OP_CLEAR:
                shadow_count = 0;
            default: ;   // unused encoding leaves the table alone
        endcase
        r.occupancy = POS_W'(shadow_count);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random field pickers, biased toward stored values so that finds,
    // removes and duplicate inserts hit often.
    // ---------------------------------------------------------------

    function automatic logic [KEY_W-1:0] pick_time();
        int unsigned r;
        logic [KEY_W-1:0] base;
        r = $urandom_range(0, 99);
        base = (shadow_count != 0) ? shadow_times[$urandom_range(0, shadow_count - 1)] : 32'h0;
        if (shadow_count != 0 && r < 40)
            return base;
        if (shadow_count != 0 && r < 50)
            return r[0] ? base + 32'd1 : base - 32'd1;   // neighbors of a stored time
        if (r < 65)
            return $urandom_range(0, 63);
        if (r < 72)
            return r[0] ? ALL_ONES : 32'h0;
        return $urandom;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (shadow_count != 0 && r < 35)
            return shadow_tags[$urandom_range(0, shadow_count - 1)];
        if (r < 50)
            return $urandom_range(0, 15);   // small pool: repeated tags
        if (r < 55)
            return ALL_ONES;
        return $urandom;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // Drives one request, waits for the accept edge, then books the response.
    // valid gets a single NBA per edge: lowered only when a gap follows.
    task automatic issue(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] tk,
                         input logic [KEY_W-1:0] te, input logic [TAG_W-1:0] tag,
                         input logic fixed, input txn_result_t fixed_res);
        int unsigned gap;
        txn_result_t predicted;
        gap = sender_calm ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= op;
        req_ch.time_key   <= tk;
        req_ch.time_end   <= te;
        req_ch.entity_key <= tag;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = table_op(op, tk, te, tag);
        table_results_q.insert(table_results_q.size(), fixed ? fixed_res : predicted);
        issued_count++;
        if (op == OP_INSERT)
            insert_count++;
        if (predicted.status == ST_FULL)
            full_count++;
        if (predicted.status == ST_MISS)
            miss_count++;
        if (shadow_count > peak_occupancy)
            peak_occupancy = shadow_count;
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
    endtask

    // Mixed traffic, insert-heavy so the table keeps some depth.
    task automatic mixed_item();
        int unsigned r;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  tk;
        logic [KEY_W-1:0]  te;
        r = $urandom_range(0, 199);
        if (r < 70)
            op = OP_INSERT;
        else if (r < 90)
            op = OP_REM_TIME;
        else if (r < 106)
            op = OP_REM_TAG;
        else if (r < 130)
            op = OP_FIND_TIME;
        else if (r < 150)
            op = OP_FIND_TAG;
        else if (r < 190)
            op = OP_RANGE;
        else if (r < 193)
            op = OP_CLEAR;
        else
            op = MODE_UNUSED;
        tk = pick_time();
        // range end: mostly a short window above the start, sometimes anywhere
        te = ($urandom_range(0, 3) == 0) ? pick_time() : tk + $urandom_range(0, 64);
        issue(op, tk, te, pick_tag(), 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned n;
        int unsigned r;
        shadow_count   = 0;
        issued_count   = 0;
        fault_count    = 0;
        checked_count  = 0;
        insert_count   = 0;
        full_count     = 0;
        miss_count     = 0;
        peak_occupancy = 0;
        sender_calm    = 1'b0;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= OP_FIND_TIME;
        req_ch.time_key   <= '0;
        req_ch.time_end   <= '0;
        req_ch.entity_key <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (n = 0; n < DIRECTED_ROWS; n++)
            issue(directed_rows[n].op, directed_rows[n].tk, directed_rows[n].te,
                  directed_rows[n].tag, directed_rows[n].fixed, directed_rows[n].res);

        // phase 1: mixed traffic on a shallow table, dense hits
        repeat (400) mixed_item();

        // phase 2: fill to capacity with scattered times, a few probes on the way
        while (shadow_count < TABLE_DEPTH)
        begin
            if ($urandom_range(0, 15) == 0)
                issue(OP_FIND_TIME, pick_time(), '0, '0, 1'b0, '0);
            else
                issue(OP_INSERT, $urandom, $urandom, $urandom, 1'b0, '0);
        end

        // full table: end bound reaches the depth, new times bounce, duplicates still report
        issue(OP_RANGE, '0, ALL_ONES, $urandom, 1'b0, '0);
        repeat (40)
        begin
            r = $urandom_range(0, 3);
            case (r)
                0: issue(OP_INSERT, $urandom, $urandom, $urandom, 1'b0, '0);
                1: issue(OP_INSERT, shadow_times[$urandom_range(0, shadow_count - 1)],
                         $urandom, $urandom, 1'b0, '0);
                2: issue(OP_FIND_TAG, $urandom,
                         $urandom, shadow_tags[$urandom_range(0, shadow_count - 1)], 1'b0, '0);
                default: issue(OP_RANGE, pick_time(), pick_time(), $urandom, 1'b0, '0);
            endcase
        end
        // one slot freed and refilled, then full again
        issue(OP_REM_TIME, shadow_times[$urandom_range(0, shadow_count - 1)], '0, '0, 1'b0, '0);
        issue(OP_INSERT, $urandom, '0, $urandom, 1'b0, '0);
        issue(OP_INSERT, $urandom, '0, $urandom, 1'b0, '0);
        issue(OP_REM_TAG, '0, '0, shadow_tags[$urandom_range(0, shadow_count - 1)], 1'b0, '0);
        issue(OP_INSERT, $urandom, '0, $urandom, 1'b0, '0);
        issue(OP_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0);

        // phase 3: mixed traffic to the item target
        for (n = 0; n < 150 || issued_count < ITEMS_TARGET; n++)
            mixed_item();

        req_ch.valid <= 1'b0;

        // drain, then a few cycles for anything stray
        while (table_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d inserts), %0d responses checked",
                 issued_count, insert_count, checked_count);
        $display("full-table rejects %0d, duplicate or miss %0d, peak occupancy %0d, faults %0d",
                 full_count, miss_count, peak_occupancy, fault_count);
        if (fault_count == 0)
            $display("PASS sorted_event_time_table_unit");
        else
            $display("FAIL sorted_event_time_table_unit");
        $finish;
    end

    // ---------------------------------------------------------------
    // Response side: random stalls, in-order compare against the booked results.
    // ready gets a single NBA per edge, same as valid on the request side.
    // ---------------------------------------------------------------
    initial
    begin : response_sink
        int unsigned stall;
        txn_result_t want;
        txn_result_t got;
        sink_calm    = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got = {rsp_ch.status, rsp_ch.position, rsp_ch.position_end, rsp_ch.occupancy};
            if (table_results_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected response: status %0d pos %0d end %0d occ %0d",
                             got.status, got.position, got.position_end, got.occupancy);
            end
            else
            begin
                want = table_results_q.pop_front();
                checked_count++;
                if (got.status !== want.status || got.position !== want.position ||
                    got.position_end !== want.position_end ||
                    got.occupancy !== want.occupancy)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"response %0d mismatch: expected st %0d pos %0d end %0d ",
                                  "occ %0d, got st %0d pos %0d end %0d occ %0d"},
                                 checked_count, want.status, want.position,
                                 want.position_end, want.occupancy, got.status,
                                 got.position, got.position_end, got.occupancy);
                end
            end
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
        end
    end

endmodule

>>> sim.f
+incdir+design
design/sett_pkg.sv
design/sett_in_if.sv
design/sett_out_if.sv
design/sett_cell.sv
design/sett_first_tree.sv
design/sorted_event_time_table_unit.sv
bench/tb_top.sv
